### src/mclw_pkg.sv
// Package for the multi-channel link watchdog.
// Holds channel count, opcodes, register indexes, payload and control types.
// No dependencies.
package mclw_pkg;

    // Number of monitored channels (1..13)
    localparam int CHANNELS = 13;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths fixed by the interface
    localparam int TMO_W   = 16;
    localparam int CHAN_W  = 4;
    localparam int FLAGS_W = 13;
    localparam int CFG_IDX_W = 3;

    // Channels with timeouts of their own
    localparam int CH_TEN    = 10;
    localparam int CH_ELEVEN = 11;
    localparam int CH_TWELVE = 12;

    // Register reset values
    localparam logic [TMO_W-1:0]  RST_COMMON_TMO = 16'd200;
    localparam logic [TMO_W-1:0]  RST_TMO_CH10   = 16'd100;
    localparam logic [TMO_W-1:0]  RST_TMO_CH11   = 16'd20;
    localparam logic [TMO_W-1:0]  RST_TMO_CH12   = 16'd100;
    localparam logic [CHAN_W-1:0] RST_CALIB_CH   = 4'd12;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FEED  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMMON_TMO = 3'd0,
        REG_TMO_CH10   = 3'd1,
        REG_TMO_CH11   = 3'd2,
        REG_TMO_CH12   = 3'd3,
        REG_CALIB_CH   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAN_W-1:0] channel;
        logic              param_saved;
    } t_item;

    typedef struct packed {
        logic [FLAGS_W-1:0] lost_flags;
        logic               channel_lost;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic apply;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic param_saved;
    } t_status;

endpackage

### src/mclw_ctrl.sv
// Controller state machine of the link watchdog.
// Sequences load, counter sweep, feed and result strobe; uses mclw_pkg.
module mclw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_op,
    input  mclw_pkg::t_status i_status,
    output mclw_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import mclw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_APPLY = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // Choose the next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    priority if (i_op == OP_TICK) n_state = S_SWEEP;
                    else if (i_op == OP_FEED)     n_state = S_APPLY;
                    else                          n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = i_status.param_saved ? S_APPLY : S_DONE;
                end
            end
            S_APPLY: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive datapath commands and handshake outputs
    always_comb begin
        o_cmd.load  = w_accept;
        o_cmd.step  = (r_state == S_SWEEP);
        o_cmd.apply = (r_state == S_APPLY);
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

### src/mclw_dp.sv
// Datapath of the link watchdog: config registers, tick counters, lost flags.
// Sweeps one counter per cycle on a tick; uses mclw_pkg.
module mclw_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mclw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mclw_pkg::TMO_W-1:0]      i_cfg_wdata,
    input  mclw_pkg::t_item                 i_item,
    input  mclw_pkg::t_cmd                  i_cmd,
    output mclw_pkg::t_status               o_status,
    output mclw_pkg::t_result               o_result
);
    import mclw_pkg::*;

    logic [TMO_W-1:0]  r_common_tmo;
    logic [TMO_W-1:0]  r_tmo_ch10;
    logic [TMO_W-1:0]  r_tmo_ch11;
    logic [TMO_W-1:0]  r_tmo_ch12;
    logic [CHAN_W-1:0] r_calib_ch;

    logic [TMO_W-1:0]    r_cnt [CHANNELS];
    logic [CHANNELS-1:0] r_lost;
    logic [IDX_W-1:0]    r_idx;
    logic [1:0]          r_op;
    logic [CHAN_W-1:0]   r_ch;
    logic                r_saved;
    logic                r_chlost;

    logic [TMO_W-1:0]  w_tmo;
    logic [TMO_W:0]    w_next;
    logic              w_hit;
    logic [CHAN_W-1:0] w_feed_ch;
    logic              w_query_bit;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_tmo <= RST_COMMON_TMO;
            r_tmo_ch10   <= RST_TMO_CH10;
            r_tmo_ch11   <= RST_TMO_CH11;
            r_tmo_ch12   <= RST_TMO_CH12;
            r_calib_ch   <= RST_CALIB_CH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COMMON_TMO: r_common_tmo <= i_cfg_wdata;
                REG_TMO_CH10:   r_tmo_ch10   <= i_cfg_wdata;
                REG_TMO_CH11:   r_tmo_ch11   <= i_cfg_wdata;
                REG_TMO_CH12:   r_tmo_ch12   <= i_cfg_wdata;
                REG_CALIB_CH:   r_calib_ch   <= i_cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Select the timeout of the channel under the sweep
    always_comb begin
        priority if (32'(r_idx) == CH_TEN)    w_tmo = r_tmo_ch10;
        else if (32'(r_idx) == CH_ELEVEN)     w_tmo = r_tmo_ch11;
        else if (32'(r_idx) == CH_TWELVE)     w_tmo = r_tmo_ch12;
        else                                  w_tmo = r_common_tmo;
    end

    assign w_next = {1'b0, r_cnt[r_idx]} + (TMO_W+1)'(1);
    assign w_hit  = (w_next >= {1'b0, w_tmo});

    // Feed the named channel, or the calibration channel after a tick
    assign w_feed_ch = (r_op == OP_TICK) ? r_calib_ch : r_ch;

    // Look up the queried channel's flag
    always_comb begin
        w_query_bit = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (32'(i_item.channel) == i) w_query_bit = r_lost[i];
        end
    end

    // Hold the item and sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step && !o_status.sweep_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_item.op;
            r_ch     <= i_item.channel;
            r_saved  <= i_item.param_saved;
            r_chlost <= (i_item.op == OP_QUERY) ? w_query_bit : 1'b0;
        end
    end

    // Advance counters and raise or drop flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cnt[i] <= '0;
            end
            r_lost <= '0;
        end else if (i_cmd.step) begin
            r_cnt[r_idx] <= w_hit ? '0 : w_next[TMO_W-1:0];
            if (w_hit) r_lost[r_idx] <= 1'b1;
        end else if (i_cmd.apply) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (32'(w_feed_ch) == i) begin
                    r_cnt[i]  <= '0;
                    r_lost[i] <= 1'b0;
                end
            end
        end
    end

    assign o_status.sweep_last  = (r_idx == IDX_W'(CHANNELS - 1));
    assign o_status.param_saved = r_saved;

    // Present the flag vector, zero above the channel count
    always_comb begin
        o_result.lost_flags = '0;
        for (int j = 0; j < FLAGS_W; j++) begin
            if (j < CHANNELS) o_result.lost_flags[j] = r_lost[j];
        end
        o_result.channel_lost = r_chlost;
    end

endmodule

### src/multi_channel_link_watchdog_top.sv
// Top level of the multi-channel link watchdog.
// Joins mclw_ctrl and mclw_dp; uses mclw_pkg.
//
// Usage:
//   Command channel: drive i_item and raise i_start; the transaction is
//   taken at a rising edge where i_start is high and o_busy is low.
//   Result channel: o_valid strobes for one cycle with o_result; the
//   receiver cannot stall it and must take it in that cycle.
//   Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_idx at
//   once; write only while o_busy is low.
// Sequence after acceptance:
//   a query or unused op goes straight to the result strobe; a feed passes
//   the apply state first; a tick sweeps every channel counter, then passes
//   the apply state when param_saved is set. o_busy falls the cycle after
//   the strobe. The tick time is set by the counter sweep, which
//   updates one channel counter per cycle.
// Reset: synchronous on i_rst_n low; clears all counters and lost flags,
// restores the register defaults and returns the controller to idle.
module multi_channel_link_watchdog_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  mclw_pkg::t_item                 i_item,
    output logic                            o_busy,
    output logic                            o_valid,
    output mclw_pkg::t_result               o_result,
    input  logic                            i_cfg_we,
    input  logic [mclw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mclw_pkg::TMO_W-1:0]      i_cfg_wdata
);
    import mclw_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mclw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_op     (i_item.op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    mclw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_result)
    );

endmodule

### src/mclw_chk.sv
// Port checker for the link watchdog top level, with its bind.
// Watches handshake and result timing; uses mclw_pkg.
module mclw_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input mclw_pkg::t_item   i_item,
    input logic              o_busy,
    input logic              o_valid
);
    import mclw_pkg::*;

    logic w_accept;
    assign w_accept = i_start && !o_busy;

    // The result strobe lasts a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // A strobe only appears while a transaction is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe without busy");

    // An accepted transaction raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("busy not raised after accept");

    // A query answers in the next cycle
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.op == OP_QUERY)) |=> o_valid)
        else $error("query result late");

    // A feed answers once the controller has passed its apply state
    a_feed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.op == OP_FEED)) |=> !o_valid ##1 o_valid)
        else $error("feed result timing wrong");

endmodule

bind multi_channel_link_watchdog_top mclw_chk u_mclw_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_item  (i_item),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
